[sv/gdg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdg_pkg: shared types and constants of the Gregorian day gap block
// Field widths, calendar constants, month tables and the stage control bundle.
// ----------------------------------------------------------------------------
package gdg_pkg;

  localparam int YEAR_BITS = 14;
  localparam int DAY_W     = 6;
  localparam int MON_W     = 4;
  localparam int GAP_BITS  = 24;

  // serial day count from the start of year 0: below 366 * 2**YEAR_BITS
  localparam int SER_W  = YEAR_BITS + 9;
  localparam int WIDE_W = (SER_W > GAP_BITS) ? SER_W : GAP_BITS;

  // year / 100 by reciprocal: estimate is exact or one low
  localparam int REC_SHIFT = YEAR_BITS + 7;
  localparam int REC_W     = YEAR_BITS + 1;
  localparam int PROD_W    = YEAR_BITS + REC_W;
  localparam int Q_W       = YEAR_BITS - 6;
  localparam logic [REC_W-1:0] RECIP_100 = REC_W'((64'd1 << REC_SHIFT) / 100);

  localparam int DOY_W = 9;

  localparam int DAYS_YEAR = 365;
  localparam int CENTURY   = 100;

  localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
  localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
  localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);

  localparam logic [DAY_W-1:0] DAY_FIRST    = DAY_W'(1);
  localparam logic [DAY_W-1:0] DAY_FEB_LEAP = DAY_W'(29);

  // load enables of the pipeline registers, shared by both lanes and the merge
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld_out;
  } stg_ctl_t;

  // month length in a common year
  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                  len = DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
      default:               len = DAY_W'(31);
    endcase
    return len;
  endfunction

  // days in the months before m, common year
  function automatic logic [DOY_W-1:0] days_before(input logic [MON_W-1:0] m);
    logic [DOY_W-1:0] n;
    case (m)
      4'd2:    n = DOY_W'(31);
      4'd3:    n = DOY_W'(59);
      4'd4:    n = DOY_W'(90);
      4'd5:    n = DOY_W'(120);
      4'd6:    n = DOY_W'(151);
      4'd7:    n = DOY_W'(181);
      4'd8:    n = DOY_W'(212);
      4'd9:    n = DOY_W'(243);
      4'd10:   n = DOY_W'(273);
      4'd11:   n = DOY_W'(304);
      4'd12:   n = DOY_W'(334);
      default: n = DOY_W'(0);
    endcase
    return n;
  endfunction

endpackage

[sv/gdg_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdg_in_if: date pair channel
// Valid/ready handshake carrying two raw dates.
// ----------------------------------------------------------------------------
interface gdg_in_if;
  import gdg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DAY_W-1:0]     first_day;
  logic [MON_W-1:0]     first_month;
  logic [YEAR_BITS-1:0] first_year;
  logic [DAY_W-1:0]     second_day;
  logic [MON_W-1:0]     second_month;
  logic [YEAR_BITS-1:0] second_year;

  modport source (
    output valid, first_day, first_month, first_year,
    output second_day, second_month, second_year,
    input  ready
  );

  modport sink (
    input  valid, first_day, first_month, first_year,
    input  second_day, second_month, second_year,
    output ready
  );
endinterface

[sv/gdg_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdg_out_if: day gap result channel
// Valid/ready handshake carrying the signed day gap.
// ----------------------------------------------------------------------------
interface gdg_out_if;
  import gdg_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [GAP_BITS-1:0] day_gap;

  modport source (output valid, day_gap, input ready);
  modport sink   (input valid, day_gap, output ready);
endinterface

[sv/gdg_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdg_lane: serial day count of one date
// Three stages: normalize and divide-estimate, century fix and leap, sum.
// ----------------------------------------------------------------------------
module gdg_lane (
  input  logic                           clk_i,
  input  gdg_pkg::stg_ctl_t              ctl_i,
  input  logic [gdg_pkg::DAY_W-1:0]      day_i,
  input  logic [gdg_pkg::MON_W-1:0]      month_i,
  input  logic [gdg_pkg::YEAR_BITS-1:0]  year_i,
  output logic [gdg_pkg::SER_W-1:0]      serial_o
);
  import gdg_pkg::*;

  // stage 1
  logic [PROD_W-1:0]    prod;
  logic                 month_ok;
  logic [DAY_W-1:0]     lim;
  logic [MON_W-1:0]     m_d;
  logic [DAY_W-1:0]     d_d;
  logic                 feb29_d;
  logic [YEAR_BITS-1:0] y1_q;
  logic [Q_W-1:0]       qest_q;
  logic [SER_W-1:0]     y365_1_q;
  logic [MON_W-1:0]     m1_q;
  logic [DAY_W-1:0]     d1_q;
  logic                 feb29_q;

  // stage 2
  logic [YEAR_BITS-1:0] q_x100;
  logic [YEAR_BITS-1:0] rem_raw;
  logic [YEAR_BITS-1:0] rem;
  logic                 rem_ge;
  logic [Q_W-1:0]       q100;
  logic                 rem_nz;
  logic                 leap;
  logic [DAY_W-1:0]     d2;
  logic [YEAR_BITS-2:0] c4_d;
  logic [Q_W-1:0]       c100_d;
  logic [Q_W-1:0]       c400_d;
  logic [DOY_W-1:0]     doy_d;
  logic [SER_W-1:0]     y365_2_q;
  logic [YEAR_BITS-2:0] c4_q;
  logic [Q_W-1:0]       c100_q;
  logic [Q_W-1:0]       c400_q;
  logic [DOY_W-1:0]     doy_q;

  // stage 3
  logic [SER_W-1:0]     serial_d;
  logic [SER_W-1:0]     serial_q;

  always_comb begin
    prod     = PROD_W'(year_i) * PROD_W'(RECIP_100);
    month_ok = (month_i >= MON_JAN) && (month_i <= MON_DEC);
    lim      = month_len(month_i);
    feb29_d  = 1'b0;
    m_d      = month_i;
    d_d      = day_i;
    if (!month_ok) begin
      m_d = MON_JAN;
      d_d = DAY_FIRST;
    end else if (day_i == '0) begin
      d_d = DAY_FIRST;
    end else if (day_i > lim) begin
      // Feb 29 survives only if the year turns out leap
      if (month_i == MON_FEB && day_i == DAY_FEB_LEAP) begin
        feb29_d = 1'b1;
      end else begin
        d_d = DAY_FIRST;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld1) begin
      y1_q     <= year_i;
      qest_q   <= prod[PROD_W-1:REC_SHIFT];
      y365_1_q <= SER_W'(year_i) * SER_W'(DAYS_YEAR);
      m1_q     <= m_d;
      d1_q     <= d_d;
      feb29_q  <= feb29_d;
    end
  end

  always_comb begin
    q_x100  = YEAR_BITS'(qest_q) * YEAR_BITS'(CENTURY);
    rem_raw = y1_q - q_x100;
    // estimate is at most one low
    rem_ge  = rem_raw >= YEAR_BITS'(CENTURY);
    rem     = rem_ge ? rem_raw - YEAR_BITS'(CENTURY) : rem_raw;
    q100    = qest_q + Q_W'(rem_ge);
    rem_nz  = |rem;
    leap    = ((y1_q[1:0] == 2'b00) && rem_nz) || (!rem_nz && (q100[1:0] == 2'b00));
    d2      = (feb29_q && !leap) ? DAY_FIRST : d1_q;
    c4_d    = (YEAR_BITS-1)'(y1_q >> 2) + (YEAR_BITS-1)'(|y1_q[1:0]);
    c100_d  = q100 + Q_W'(rem_nz);
    c400_d  = Q_W'(q100 >> 2) + Q_W'(rem_nz || (q100[1:0] != 2'b00));
    doy_d   = days_before(m1_q) + DOY_W'(leap && (m1_q > MON_FEB)) + DOY_W'(d2);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld2) begin
      y365_2_q <= y365_1_q;
      c4_q     <= c4_d;
      c100_q   <= c100_d;
      c400_q   <= c400_d;
      doy_q    <= doy_d;
    end
  end

  assign serial_d = y365_2_q + SER_W'(c4_q) - SER_W'(c100_q) + SER_W'(c400_q)
                  + SER_W'(doy_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld3) begin
      serial_q <= serial_d;
    end
  end

  assign serial_o = serial_q;

endmodule

[sv/gdg_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdg_merge: combine the two lane counts
// Absolute difference less one, held in the output register.
// ----------------------------------------------------------------------------
module gdg_merge (
  input  logic                              clk_i,
  input  gdg_pkg::stg_ctl_t                 ctl_i,
  input  logic [gdg_pkg::SER_W-1:0]         serial_a_i,
  input  logic [gdg_pkg::SER_W-1:0]         serial_b_i,
  output logic signed [gdg_pkg::GAP_BITS-1:0] day_gap_o
);
  import gdg_pkg::*;

  logic [WIDE_W:0]            diff;
  logic [WIDE_W:0]            gap;
  logic signed [GAP_BITS-1:0] day_gap_q;

  always_comb begin
    diff = (WIDE_W+1)'(serial_a_i) - (WIDE_W+1)'(serial_b_i);
    // a < b: ~(a - b) equals b - a - 1
    gap  = diff[WIDE_W] ? ~diff : diff - (WIDE_W+1)'(1);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_out) begin
      day_gap_q <= gap[GAP_BITS-1:0];
    end
  end

  assign day_gap_o = day_gap_q;

endmodule

[sv/gregorian_day_gap_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_day_gap_top: days between two Gregorian dates, less one
//
//   channel | dir | payload                                      | handshake
//   in_i    | in  | first/second day, month, year (raw)          | valid/ready
//   out_o   | out | day_gap, signed, -1 for equal dates          | valid/ready
//
// One date pair per cycle while out_o does not stall; after its transfer a
// result passes the lane pipeline (divide estimate, century fix, sum)
// and then the output register of the merge.
// Reset clears the stage valid bits only; no clearing pass.
// in_i.ready drops only when all four stages hold items and out_o stalls.
// ----------------------------------------------------------------------------
module gregorian_day_gap_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  gdg_in_if.sink    in_i,
  gdg_out_if.source out_o
);
  import gdg_pkg::*;

  localparam logic GAP_FITS = (SER_W <= GAP_BITS - 1);

  stg_ctl_t         ctl;
  logic             v1_q, v2_q, v3_q, vo_q;
  logic             rdy1, rdy2, rdy3, rdy_o;
  logic [SER_W-1:0] serial_a;
  logic [SER_W-1:0] serial_b;

  // a stage takes new data when empty or when its successor takes
  assign rdy_o = !vo_q || out_o.ready;
  assign rdy3  = !v3_q || rdy_o;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;

  assign ctl.ld1    = rdy1;
  assign ctl.ld2    = rdy2;
  assign ctl.ld3    = rdy3;
  assign ctl.ld_out = rdy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1)  v1_q <= in_i.valid;
      if (rdy2)  v2_q <= v1_q;
      if (rdy3)  v3_q <= v2_q;
      if (rdy_o) vo_q <= v3_q;
    end
  end

  gdg_lane u_lane_a (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .day_i    (in_i.first_day),
    .month_i  (in_i.first_month),
    .year_i   (in_i.first_year),
    .serial_o (serial_a)
  );

  gdg_lane u_lane_b (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .day_i    (in_i.second_day),
    .month_i  (in_i.second_month),
    .year_i   (in_i.second_year),
    .serial_o (serial_b)
  );

  gdg_merge u_merge (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .serial_a_i (serial_a),
    .serial_b_i (serial_b),
    .day_gap_o  (out_o.day_gap)
  );

  assign in_i.ready  = rdy1;
  assign out_o.valid = vo_q;

  // an empty output register means the whole chain can move
  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vo_q |-> in_i.ready)
    else $error("input stalled with empty output register");

  // a full, stalled pipeline must not take another transfer
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && vo_q && !out_o.ready) |-> !in_i.ready)
    else $error("transfer taken into a full pipeline");

  // result is either -1 or a non-negative gap when it fits the field
  a_gap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (!GAP_FITS || (out_o.day_gap == '1) || !out_o.day_gap[GAP_BITS-1]))
    else $error("day gap out of range");

endmodule

[verif/gregorian_day_gap_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_day_gap_top_tb: self-checking bench for the Gregorian day gap block
// Drives raw date pairs, predicts each day gap from the calendar rules, and
// compares every output transfer in order, under varying back-pressure.
// ----------------------------------------------------------------------------
module gregorian_day_gap_top_tb;
  import gdg_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;

  typedef struct packed {
    logic [DAY_W-1:0]     first_day;
    logic [MON_W-1:0]     first_month;
    logic [YEAR_BITS-1:0] first_year;
    logic [DAY_W-1:0]     second_day;
    logic [MON_W-1:0]     second_month;
    logic [YEAR_BITS-1:0] second_year;
  } date_pair_t;

  logic clk;
  logic rst_n;

  gdg_in_if  pair_bus ();
  gdg_out_if gap_bus ();

  gregorian_day_gap_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (pair_bus),
    .out_o  (gap_bus)
  );

  logic signed [GAP_BITS-1:0] gap_q[$];
  logic signed [GAP_BITS-1:0] want_gap;
  int                         fail_cnt = 0;
  int                         quiet_cycles = 0;
  int                         send_idle_pct;
  int                         recv_idle_pct;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic bit leap_year(input longint unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint unsigned days_in_month(input int unsigned m, input bit leap);
    case (m)
      2:             return leap ? 64'd29 : 64'd28;
      4, 6, 9, 11:   return 64'd30;
      default:       return 64'd31;
    endcase
  endfunction

  // day count from the start of year 0 after normalizing the raw date
  function automatic longint unsigned day_serial(input logic [DAY_W-1:0] d,
                                                 input logic [MON_W-1:0] m,
                                                 input logic [YEAR_BITS-1:0] y);
    longint unsigned yr;
    longint unsigned dd;
    longint unsigned total;
    int unsigned     mon;
    bit              leap;
    yr   = 64'(y);
    leap = leap_year(yr);
    if (m < MON_JAN || m > MON_DEC) begin
      mon = 32'(MON_JAN);
      dd  = 64'(DAY_FIRST);
    end else begin
      mon = 32'(m);
      dd  = 64'(d);
      if (d < DAY_FIRST || 64'(d) > days_in_month(mon, leap)) dd = 64'(DAY_FIRST);
    end
    total = 365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400;
    for (int unsigned k = 1; k < mon; k++) total += days_in_month(k, leap);
    return total + dd;
  endfunction

  function automatic logic signed [GAP_BITS-1:0] day_gap_of(input date_pair_t p);
    longint unsigned s1;
    longint unsigned s2;
    longint unsigned diff;
    s1   = day_serial(p.first_day, p.first_month, p.first_year);
    s2   = day_serial(p.second_day, p.second_month, p.second_year);
    diff = (s1 >= s2) ? s1 - s2 : s2 - s1;
    return GAP_BITS'(diff - 64'd1);
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic date_pair_t make_pair(input int d1, input int m1, input int y1,
                                           input int d2, input int m2, input int y2);
    date_pair_t p;
    p.first_day    = DAY_W'(d1);
    p.first_month  = MON_W'(m1);
    p.first_year   = YEAR_BITS'(y1);
    p.second_day   = DAY_W'(d2);
    p.second_month = MON_W'(m2);
    p.second_year  = YEAR_BITS'(y2);
    return p;
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t p;
    int         pick;
    int         span;
    pick = $urandom_range(99);
    if (pick < 30) begin
      // raw fields over their full width
      p.first_day    = DAY_W'($urandom);
      p.first_month  = MON_W'($urandom);
      p.first_year   = YEAR_BITS'($urandom);
      p.second_day   = DAY_W'($urandom);
      p.second_month = MON_W'($urandom);
      p.second_year  = YEAR_BITS'($urandom);
    end else begin
      p.first_day    = DAY_W'($urandom_range(31, 1));
      p.first_month  = MON_W'($urandom_range(MON_DEC, MON_JAN));
      p.first_year   = YEAR_BITS'($urandom_range((1 << YEAR_BITS) - 1, 1));
      p.second_day   = DAY_W'($urandom_range(31, 1));
      p.second_month = MON_W'($urandom_range(MON_DEC, MON_JAN));
      if (pick < 60) begin
        // nearby years, often across leap boundaries
        span = $urandom_range(8);
        p.second_year = (p.first_year > span) ? YEAR_BITS'(p.first_year - span)
                                              : YEAR_BITS'(p.first_year + span);
      end else begin
        p.second_year = YEAR_BITS'($urandom_range((1 << YEAR_BITS) - 1, 1));
      end
      if (pick < 36) begin
        p.second_day   = p.first_day;
        p.second_month = p.first_month;
        p.second_year  = p.first_year;
      end else if (pick < 44) begin
        p.first_month  = MON_FEB;
        p.first_day    = DAY_FEB_LEAP;
        p.first_year   = YEAR_BITS'($urandom_range(((1 << YEAR_BITS) - 1) / 100) * 100);
      end
    end
    return p;
  endfunction

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic send_pair(input date_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      pair_bus.valid <= 1'b0;
      @(negedge clk);
    end
    pair_bus.valid        <= 1'b1;
    pair_bus.first_day    <= p.first_day;
    pair_bus.first_month  <= p.first_month;
    pair_bus.first_year   <= p.first_year;
    pair_bus.second_day   <= p.second_day;
    pair_bus.second_month <= p.second_month;
    pair_bus.second_year  <= p.second_year;
    @(posedge clk);
    while (!pair_bus.ready) @(posedge clk);
    gap_q.push_back(day_gap_of(p));
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    while (gap_q.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed_cases();
    send_pair(make_pair(15, 6, 2020, 15, 6, 2020));          // equal dates
    send_pair(make_pair(1, 1, 1, 1, 1, 1));
    send_pair(make_pair(1, 1, 1, 2, 1, 1));                  // adjacent days
    send_pair(make_pair(31, 12, 16383, 1, 1, 0));            // widest span
    send_pair(make_pair(1, 1, 0, 31, 12, 16383));
    send_pair(make_pair(29, 2, 0, 1, 3, 0));                 // year zero is leap
    send_pair(make_pair(29, 2, 2000, 1, 3, 2000));
    send_pair(make_pair(29, 2, 1900, 1, 2, 1900));           // Feb 29, not leap
    send_pair(make_pair(29, 2, 2004, 28, 2, 2004));
    send_pair(make_pair(30, 2, 2000, 1, 2, 2000));           // Feb 30
    send_pair(make_pair(31, 4, 2021, 1, 4, 2021));           // April 31
    send_pair(make_pair(0, 7, 1999, 1, 7, 1999));            // day zero
    send_pair(make_pair(63, 8, 1999, 63, 1, 1999));          // day all ones
    send_pair(make_pair(17, 0, 1500, 1, 1, 1500));           // month zero
    send_pair(make_pair(5, 13, 1500, 9, 14, 1500));
    send_pair(make_pair(63, 15, 16383, 0, 0, 0));
    send_pair(make_pair(31, 12, 1999, 1, 1, 2000));
    send_pair(make_pair(28, 2, 2100, 1, 3, 2100));
    send_pair(make_pair(31, 12, 2400, 1, 1, 2400));
    send_pair(make_pair(10, 10, 8191, 10, 10, 8192));
    send_pair(make_pair(1, 3, 1600, 29, 2, 1600));
  endtask

  task automatic test_random_pairs(input int count);
    for (int i = 0; i < count; i++) send_pair(random_pair());
  endtask

  // hold the sender until every outstanding gap has been checked
  task automatic test_drain_pause(input int count);
    test_random_pairs(count);
    pair_bus.valid <= 1'b0;
    @(negedge clk);
    wait_for_results();
    test_random_pairs(count);
  endtask

  // ---------------------------------------------------------------- receiver
  always @(negedge clk) begin
    gap_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (gap_bus.valid && gap_bus.ready) begin
        if (gap_q.size() == 0) begin
          $error("day_gap: no transfer expected, actual %0d", gap_bus.day_gap);
          fail_cnt++;
        end else begin
          want_gap = gap_q.pop_front();
          if (gap_bus.day_gap !== want_gap) begin
            $error("day_gap: expected %0d, actual %0d", want_gap, gap_bus.day_gap);
            fail_cnt++;
          end
        end
      end
      if ((pair_bus.valid && pair_bus.ready) || (gap_bus.valid && gap_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    send_idle_pct         = 22;
    recv_idle_pct         = 76;
    rst_n                 = 1'b0;
    pair_bus.valid        = 1'b0;
    pair_bus.first_day    = '0;
    pair_bus.first_month  = '0;
    pair_bus.first_year   = '0;
    pair_bus.second_day   = '0;
    pair_bus.second_month = '0;
    pair_bus.second_year  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_random_pairs(520);

    send_idle_pct = 76;
    recv_idle_pct = 22;
    test_drain_pause(270);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_pairs(540);

    pair_bus.valid <= 1'b0;
    @(negedge clk);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
